// File: sv/modbus_force_frame_to_scaled_int16_macros.svh
// assertion helpers
`ifndef MODBUS_FORCE_FRAME_TO_SCALED_INT16_MACROS_SVH
`define MODBUS_FORCE_FRAME_TO_SCALED_INT16_MACROS_SVH
`define MF_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define MF_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: sv/mfs_pkg.sv
`default_nettype none
package mfs_pkg;
    localparam logic [4:0] FrameLen   = 5'd29;
    localparam logic [7:0] ByteCntOk  = 8'h18;
    localparam logic [7:0] FuncCodeOk = 8'h04;
    localparam logic [7:0] StationRst = 8'h01;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEN   = 2'd1,
        ST_BAD_COUNT = 2'd2,
        ST_BAD_FUNC  = 2'd3
    } t_status;

    // x*100 in single precision (rne), then saturate/truncate to int16
    function automatic logic [15:0] scale_word(input logic [31:0] bits);
        logic        sgn;
        logic [7:0]  ex;
        logic [23:0] man;
        logic [30:0] prod;
        logic [23:0] rm;
        logic        rnd;
        logic [24:0] rsum;
        logic [8:0]  e2;
        logic [23:0] m2;
        logic [9:0]  sh;
        logic [15:0] mag;
        logic [15:0] res;
        sgn = bits[31];
        ex  = bits[30:23];
        man = {(ex != 8'd0), bits[22:0]};
        res = 16'd0;
        if (ex == 8'hFF && bits[22:0] != 23'd0) begin
            res = 16'd0;
        end else if (ex == 8'hFF) begin
            res = sgn ? 16'h8000 : 16'h7FFF;
        end else begin
            prod = man * 7'd100;
            // normalize product to 24 bits, product < 2^31
            if (prod[30]) begin
                rm  = prod[30:7];
                rnd = prod[6] & ((|prod[5:0]) | prod[7]);
                e2  = {1'b0, ex} + 9'd7;
            end else if (prod[29]) begin
                rm  = prod[29:6];
                rnd = prod[5] & ((|prod[4:0]) | prod[6]);
                e2  = {1'b0, ex} + 9'd6;
            end else begin
                // subnormal input: value far below 1, result truncates to 0
                rm  = prod[28:5];
                rnd = 1'b0;
                e2  = 9'd0;
            end
            rsum = {1'b0, rm} + {24'd0, rnd};
            if (rsum[24]) begin
                m2 = rsum[24:1];
                e2 = e2 + 9'd1;
            end else begin
                m2 = rsum[23:0];
            end
            // value = m2 * 2^(e2-150); int part when e2 >= 127
            if (ex == 8'd0 || e2 < 9'd127) begin
                mag = 16'd0;
                res = 16'd0;
            end else if (e2 > 9'd141) begin
                res = sgn ? 16'h8000 : 16'h7FFF;
            end else begin
                sh  = 10'd150 - {1'b0, e2};
                mag = 16'(m2 >> sh[4:0]);
                if (!sgn) res = mag[15] ? 16'h7FFF : mag;
                else res = (mag > 16'd32768) ? 16'h8000 : (16'd0 - mag);
            end
        end
        return res;
    endfunction
endpackage
`default_nettype wire

// File: sv/modbus_force_frame_to_scaled_int16.sv
// Modbus RTU read-input-registers response parser: one byte per cycle, each
// accepted byte is registered and its float (on the fourth byte) scaled in one
// pass, so the input takes a byte every cycle. A good 29-byte frame gives a
// force result then a moment result; a bad frame one status result. The
// results of a frame enter a two-entry output queue when its registered
// frame-end byte leaves stage 1. The two results of a good frame leave that
// queue one after the other, while bytes keep flowing meanwhile; the input
// stalls only when a registered frame-end byte finds no room in that queue
// for its results.
`default_nettype none
`include "modbus_force_frame_to_scaled_int16_macros.svh"
module modbus_force_frame_to_scaled_int16 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_end,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_frame_kind,
    output logic signed [15:0] o_value_x,
    output logic signed [15:0] o_value_y,
    output logic signed [15:0] o_value_z,
    output logic [1:0]       o_status,
    output logic             o_station_mismatch,
    output logic             o_last
);
    typedef struct packed {
        logic        kind;
        logic [15:0] x, y, z;
        logic [1:0]  status;
        logic        mism;
        logic        last;
    } t_res;

    logic [7:0]  r_station;
    logic [4:0]  r_pos;
    logic [7:0]  r_addr, r_func, r_cnt;
    logic [23:0] r_fb;
    logic [15:0] r_sv [6];
    // stage 1: registered byte
    logic        r_s1_v;
    logic [7:0]  r_s1_b;
    logic        r_s1_end;
    logic [4:0]  r_s1_pos;
    // output queue of two results
    t_res        r_q [2];
    logic [1:0]  r_cnt_q;

    logic        acc, pop;
    logic        s1_emit;
    logic        s1_go;
    logic        s1_fire;
    logic [1:0]  q_after;
    logic [1:0]  s1_n;
    t_res        res0, res1;
    logic [15:0] scaled;
    logic [4:0]  p;
    logic        mism;

    assign o_cfg_ready = i_rst_n;
    // a frame-end byte leaves stage 1 only when its results fit the queue
    assign q_after = r_cnt_q - {1'b0, pop};
    assign s1_go   = !r_s1_v || !r_s1_end || ({1'b0, q_after} + {1'b0, s1_n} <= 3'd2);
    assign s1_fire = r_s1_v && s1_go;
    assign o_ready = i_rst_n && s1_go;
    assign acc = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= mfs_pkg::StationRst;
        end else if (i_cfg_valid) begin
            r_station <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= acc || (r_s1_v && !s1_go);
            if (acc) begin
                r_s1_pos <= r_pos;
                if (i_frame_end) r_pos <= '0;
                else if (r_pos != 5'd31) r_pos <= r_pos + 5'd1;
            end
        end
        if (acc) begin
            r_s1_b   <= i_rx_byte;
            r_s1_end <= i_frame_end;
        end
    end

    assign p      = r_s1_pos - 5'd3;
    assign scaled = mfs_pkg::scale_word({r_fb, r_s1_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0; r_func <= '0; r_cnt <= '0; r_fb <= '0;
        end else if (s1_fire) begin
            case (r_s1_pos)
                5'd0: r_addr <= r_s1_b;
                5'd1: r_func <= r_s1_b;
                5'd2: r_cnt  <= r_s1_b;
                default: begin
                    if (r_s1_pos >= 5'd3 && r_s1_pos <= 5'd26) begin
                        if (p[1:0] != 2'd3) r_fb <= {r_fb[15:0], r_s1_b};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_pos >= 5'd3 && r_s1_pos <= 5'd26 && p[1:0] == 2'd3)
            r_sv[3'(p[4:2])] <= scaled;
    end

    // result formation uses state as of the frame-end byte
    always_comb begin
        mism = (r_addr != r_station);
        res0 = '0;
        res1 = '0;
        s1_n = 2'd0;
        res0.last = 1'b1;
        if (r_s1_pos + 5'd1 != mfs_pkg::FrameLen) begin
            res0.status = mfs_pkg::ST_BAD_LEN;
            s1_n = 2'd1;
        end else if (r_cnt != mfs_pkg::ByteCntOk) begin
            res0.status = mfs_pkg::ST_BAD_COUNT;
            s1_n = 2'd1;
        end else if (r_func != mfs_pkg::FuncCodeOk) begin
            res0.status = mfs_pkg::ST_BAD_FUNC;
            res0.mism = mism;
            s1_n = 2'd1;
        end else begin
            res0 = '{kind: 1'b0, x: r_sv[0], y: r_sv[1], z: r_sv[2],
                     status: mfs_pkg::ST_OK, mism: mism, last: 1'b0};
            res1 = '{kind: 1'b1, x: r_sv[3], y: r_sv[4], z: r_sv[5],
                     status: mfs_pkg::ST_OK, mism: mism, last: 1'b1};
            s1_n = 2'd2;
        end
    end
    assign s1_emit = s1_fire && r_s1_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_q <= '0;
        end else begin
            r_cnt_q <= q_after + (s1_emit ? s1_n : 2'd0);
            if (s1_emit && q_after == 2'd0) begin
                r_q[0] <= res0;
                r_q[1] <= res1;
            end else if (s1_emit) begin
                if (pop) r_q[0] <= r_q[1];
                r_q[1] <= res0;
            end else if (pop) begin
                r_q[0] <= r_q[1];
            end
        end
    end

    assign o_valid            = (r_cnt_q != 2'd0);
    assign o_frame_kind       = r_q[0].kind;
    assign o_value_x          = r_q[0].x;
    assign o_value_y          = r_q[0].y;
    assign o_value_z          = r_q[0].z;
    assign o_status           = r_q[0].status;
    assign o_station_mismatch = r_q[0].mism;
    assign o_last             = r_q[0].last;

    `MF_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, s1_emit && s1_n == 2'd2,
        q_after == 2'd0, "queue overflow")
    `MF_ASSERT_IMPL(a_status_last, i_clk, i_rst_n, o_valid && o_status != mfs_pkg::ST_OK,
        o_last, "status result must be last")
    `MF_ASSERT_NEXT(a_pos_reset, i_clk, i_rst_n, acc && i_frame_end,
        r_pos == 5'd0, "position not cleared")
endmodule
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              kind;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        mfs_pkg::t_status  status;
        logic              mism;
        logic              last;
    } t_frame_result;

    typedef struct {
        logic [7:0]       data;
        logic             eof;
        logic             typed;
        mfs_pkg::t_status status;
    } t_byte_row;

    localparam int StallLimit = 3000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [7:0]        i_rx_byte = 8'd0;
    logic              i_frame_end = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [7:0]        i_cfg_data = 8'd0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_frame_kind;
    logic signed [15:0] o_value_x;
    logic signed [15:0] o_value_y;
    logic signed [15:0] o_value_z;
    logic [1:0]        o_status;
    logic              o_station_mismatch;
    logic              o_last;

    modbus_force_frame_to_scaled_int16 dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  station_model;
    logic [4:0]  pos_model;
    logic [7:0]  addr_model;
    logic [7:0]  func_model;
    logic [7:0]  count_model;
    logic [23:0] partial_model;
    logic [15:0] scaled_model [6];

    t_frame_result pending_results[$];
    int errors = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int frames_good = 0;
    int frames_bad = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    // value * 100 rounded to single precision, then truncated into int16
    function automatic logic [15:0] scaled_int16(input logic [31:0] bits);
        logic [7:0]  ex;
        logic [31:0] prod;
        logic [31:0] rnd;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] mag;
        int          msb;
        int          sh;
        int          expo;
        ex = bits[30:23];
        if (ex == 8'hFF) begin
            if (bits[22:0] != 0) return 16'd0;
            return bits[31] ? 16'h8000 : 16'h7FFF;
        end
        prod = {(ex != 0), bits[22:0]} * 32'd100;
        if (prod == 0) return 16'd0;
        msb = 0;
        for (int i = 0; i < 32; i++) if (prod[i]) msb = i;
        sh = (msb > 23) ? msb - 23 : 0;
        rnd = prod >> sh;
        if (sh > 0) begin
            rem = prod & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            if (rem > half || (rem == half && rnd[0])) rnd = rnd + 1;
        end
        expo = ((ex == 0) ? 1 : int'(ex)) - 150 + sh;
        if (expo >= 0) begin
            mag = 32'hFFFF_FFFF;
        end else if (expo <= -32) begin
            mag = 0;
        end else begin
            mag = rnd >> (-expo);
        end
        if (!bits[31]) return (mag > 32767) ? 16'h7FFF : mag[15:0];
        return (mag > 32768) ? 16'h8000 : 16'(32'd0 - mag);
    endfunction

    function automatic t_frame_result status_result(input mfs_pkg::t_status st,
                                                    input logic mm);
        t_frame_result r;
        r.kind = 1'b0;
        r.vx = 0;
        r.vy = 0;
        r.vz = 0;
        r.status = st;
        r.mism = mm;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic eof, input logic record);
        logic [4:0]    p;
        int            off;
        logic          mm;
        t_frame_result r;
        p = pos_model;
        if (p == 0) addr_model = b;
        else if (p == 1) func_model = b;
        else if (p == 2) count_model = b;
        else if (p <= 26) begin
            off = int'(p) - 3;
            if ((off % 4) < 3) partial_model = {partial_model[15:0], b};
            else scaled_model[off / 4] = scaled_int16({partial_model, b});
        end
        if (!eof) begin
            if (pos_model != 5'd31) pos_model = pos_model + 5'd1;
            return;
        end
        pos_model = 0;
        mm = (addr_model != station_model);
        if (int'(p) + 1 != int'(mfs_pkg::FrameLen))
            r = status_result(mfs_pkg::ST_BAD_LEN, 1'b0);
        else if (count_model != mfs_pkg::ByteCntOk)
            r = status_result(mfs_pkg::ST_BAD_COUNT, 1'b0);
        else if (func_model != mfs_pkg::FuncCodeOk)
            r = status_result(mfs_pkg::ST_BAD_FUNC, mm);
        else begin
            frames_good++;
            if (record) begin
                r.kind = 1'b0;
                r.vx = scaled_model[0];
                r.vy = scaled_model[1];
                r.vz = scaled_model[2];
                r.status = mfs_pkg::ST_OK;
                r.mism = mm;
                r.last = 1'b0;
                pending_results.push_back(r);
                r.kind = 1'b1;
                r.vx = scaled_model[3];
                r.vy = scaled_model[4];
                r.vz = scaled_model[5];
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            return;
        end
        frames_bad++;
        if (record) pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        errors++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        logic rdy;
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        i_frame_end <= eof;
        do begin
            @(negedge i_clk);
            rdy = o_ready;
            @(posedge i_clk);
        end while (!rdy);
        bytes_sent++;
    endtask

    task automatic write_station(input logic [7:0] id);
        logic rdy;
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= id;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        station_model = id;
    endtask

    function automatic logic [31:0] pick_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(9))
            0: f = {f[31], 31'd0};
            1: f = {f[31], 8'hFF, 23'd0};
            2: f = {f[31], 8'hFF, f[22:1], 1'b1};
            3: ;
            4: f[30:23] = 8'($urandom_range(120, 141));
            5: f = {f[31], 31'h43A3_D70A + 31'($urandom_range(0, 8)) - 31'd4};
            6: f[30:23] = 8'h00;
            7: f[30:23] = 8'($urandom_range(200, 254));
            8: f[30:23] = 8'($urandom_range(100, 126));
            default: f = {f[31], 8'($urandom_range(127, 135)), f[22:16], 16'd0};
        endcase
        return f;
    endfunction

    task automatic send_and_predict(input logic [7:0] b, input logic eof);
        send_byte(b, eof);
        parse_byte(b, eof, 1'b1);
    endtask

    task automatic random_frame();
        logic [7:0]  hdr [3];
        logic [31:0] f;
        int          len;
        int          kind;
        kind = $urandom_range(99);
        hdr[0] = ($urandom_range(1) != 0) ? station_model : 8'($urandom);
        hdr[1] = mfs_pkg::FuncCodeOk;
        hdr[2] = mfs_pkg::ByteCntOk;
        if (kind >= 85) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) send_and_predict(8'($urandom), i == len - 1);
            return;
        end
        if (kind >= 77) hdr[1] = 8'($urandom);
        else if (kind >= 70) hdr[2] = 8'($urandom);
        for (int i = 0; i < 3; i++) send_and_predict(hdr[i], 1'b0);
        for (int k = 0; k < 6; k++) begin
            f = pick_float();
            for (int i = 3; i >= 0; i--) send_and_predict(f[8*i +: 8], 1'b0);
        end
        send_and_predict(8'($urandom), 1'b0);
        send_and_predict(8'($urandom), 1'b1);
    endtask

    // receiver side, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(negedge i_clk) begin
        t_frame_result e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = pending_results.pop_front();
                if (o_frame_kind !== e.kind) report_mismatch("frame_kind");
                if (o_value_x !== e.vx)
                    report_mismatch($sformatf("value_x %0d exp %0d", o_value_x, e.vx));
                if (o_value_y !== e.vy)
                    report_mismatch($sformatf("value_y %0d exp %0d", o_value_y, e.vy));
                if (o_value_z !== e.vz)
                    report_mismatch($sformatf("value_z %0d exp %0d", o_value_z, e.vz));
                if (o_status !== e.status)
                    report_mismatch($sformatf("status %0d exp %0d", o_status, e.status));
                if (o_station_mismatch !== e.mism) report_mismatch("station_mismatch");
                if (o_last !== e.last) report_mismatch("last");
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    t_byte_row directed_rows [] = '{
        '{8'h00, 1'b1, 1'b1, mfs_pkg::ST_BAD_LEN},
        '{8'hFF, 1'b1, 1'b1, mfs_pkg::ST_BAD_LEN},
        '{8'h01, 1'b0, 1'b0, mfs_pkg::ST_OK},
        '{8'h04, 1'b0, 1'b0, mfs_pkg::ST_OK},
        '{8'h18, 1'b1, 1'b1, mfs_pkg::ST_BAD_LEN},
        '{8'hAA, 1'b0, 1'b0, mfs_pkg::ST_OK},
        '{8'h55, 1'b1, 1'b1, mfs_pkg::ST_BAD_LEN},
        '{8'h80, 1'b1, 1'b1, mfs_pkg::ST_BAD_LEN},
        '{8'h7F, 1'b0, 1'b0, mfs_pkg::ST_OK},
        '{8'h01, 1'b0, 1'b0, mfs_pkg::ST_OK},
        '{8'hFE, 1'b0, 1'b0, mfs_pkg::ST_OK},
        '{8'h00, 1'b1, 1'b1, mfs_pkg::ST_BAD_LEN}
    };

    initial begin
        int phase_target;
        station_model = mfs_pkg::StationRst;
        pos_model = 0;
        addr_model = 0;
        func_model = 0;
        count_model = 0;
        partial_model = 0;
        foreach (scaled_model[i]) scaled_model[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 36;
        recv_idle = 87;
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].data, directed_rows[i].eof);
            if (directed_rows[i].typed) begin
                pending_results.push_back(status_result(directed_rows[i].status, 1'b0));
                parse_byte(directed_rows[i].data, directed_rows[i].eof, 1'b0);
            end else begin
                parse_byte(directed_rows[i].data, directed_rows[i].eof, 1'b1);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: write_station(8'h00);
                1: write_station(8'hFF);
                default: write_station(8'($urandom));
            endcase
            send_idle = (phase == 0) ? 36 : (phase == 1) ? 87 : 0;
            recv_idle = (phase == 0) ? 87 : (phase == 1) ? 36 : 0;
            // long receiver stall so the input backs up
            if (phase == 2) hold_cycles = 200;
            phase_target = bytes_sent + 140;
            while (bytes_sent < phase_target) random_frame();
        end
        write_station(mfs_pkg::StationRst);
        repeat (3) random_frame();

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("run covered %0d bytes, %0d good and %0d bad frames, %0d results checked",
                 bytes_sent, frames_good, frames_bad, results_seen);
        $display("station id set to 0, 255, random and reset value, with three idle mixes");
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
